// ===== src/dsmpo_pkg.sv =====
// ----------------------------------------------------------------------------
// dsmpo_pkg: shared types and constants of the page ownership engine
// Holds the request and result structures, the page entry layout, the mode
// and action codes and the default parameter values.
// ----------------------------------------------------------------------------
package dsmpo_pkg;

  // Default sizes of the cluster and of the page table.
  localparam int unsigned NodesDefault        = 16;
  localparam int unsigned FilesDefault        = 4;
  localparam int unsigned PagesPerFileDefault = 256;

  // Request modes.
  localparam logic [2:0] MODE_REMOTE_READ  = 3'd0;
  localparam logic [2:0] MODE_REMOTE_WRITE = 3'd1;
  localparam logic [2:0] MODE_REMOTE_INVAL = 3'd2;
  localparam logic [2:0] MODE_LOCAL_READ   = 3'd3;
  localparam logic [2:0] MODE_LOCAL_WRITE  = 3'd4;
  localparam logic [2:0] MODE_READ_REPLY   = 3'd5;
  localparam logic [2:0] MODE_WRITE_REPLY  = 3'd6;

  // Message actions.
  localparam logic [3:0] ACT_GRANT     = 4'd0;
  localparam logic [3:0] ACT_READ_REQ  = 4'd1;
  localparam logic [3:0] ACT_WRITE_REQ = 4'd2;
  localparam logic [3:0] ACT_INVAL     = 4'd3;
  localparam logic [3:0] ACT_RESP      = 4'd4;
  localparam logic [3:0] ACT_FWD_READ  = 4'd5;
  localparam logic [3:0] ACT_FWD_WRITE = 4'd6;
  localparam logic [3:0] ACT_ACK       = 4'd7;
  localparam logic [3:0] ACT_NONE      = 4'd8;

  // Configuration register indexes.
  localparam logic [1:0] REG_NODE_ID      = 2'd0;
  localparam logic [1:0] REG_MAIN_NODE_ID = 2'd1;

  typedef struct packed {
    logic [2:0]  mode;
    logic [1:0]  file_id;
    logic [7:0]  page_index;
    logic [3:0]  src_node;
    logic [15:0] copyset_in;
    logic [15:0] request_tag;
  } item_t;

  typedef struct packed {
    logic [3:0]  action;
    logic [3:0]  dest_node;
    logic [3:0]  msg_src;
    logic [1:0]  file_out;
    logic [7:0]  page_out;
    logic [15:0] copyset_out;
    logic [15:0] tag_out;
    logic        drop_write;
    logic        drop_all;
    logic        grant_write;
    logic        last;
  } result_t;

  // Classified request handed from the front to the back.
  typedef struct packed {
    logic  oor;
    item_t item;
  } cmd_t;

  // One page table entry, 23 bits.
  typedef struct packed {
    logic        created;
    logic [15:0] copyset;
    logic [3:0]  owner;
    logic        write;
    logic        valid;
  } entry_t;

  localparam int unsigned EntryWidth = $bits(entry_t);

  // Copyset bits that stand for real nodes.
  function automatic logic [15:0] node_mask(int unsigned nodes);
    logic [31:0] m;
    m = (32'd1 << nodes) - 32'd1;
    if (nodes >= 16) begin
      return 16'hFFFF;
    end
    return m[15:0];
  endfunction

endpackage

// ===== src/dsmpo_ram.sv =====
// ----------------------------------------------------------------------------
// dsmpo_ram: generic single-port-write RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module dsmpo_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  // Storage write and registered read.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

// ===== src/dsmpo_fifo.sv =====
// ----------------------------------------------------------------------------
// dsmpo_fifo: two-entry queue
// Decouples producer and consumer; full and empty flags from a fill count.
// ----------------------------------------------------------------------------
module dsmpo_fifo #(
  parameter int unsigned Width = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [Width-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [Width-1:0] data_o,
  output logic             empty_o
);

  logic [Width-1:0] mem_q [2];
  logic             wptr_q, rptr_q;
  logic [1:0]       count_q;
  logic             do_push, do_pop;

  assign full_o  = (count_q == 2'd2);
  assign empty_o = (count_q == 2'd0);
  assign data_o  = mem_q[rptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  // Pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= 1'b0;
      rptr_q  <= 1'b0;
      count_q <= 2'd0;
    end else begin
      if (do_push) begin
        wptr_q <= !wptr_q;
      end
      if (do_pop) begin
        rptr_q <= !rptr_q;
      end
      count_q <= count_q + {1'b0, do_push} - {1'b0, do_pop};
    end
  end

  // Entry storage.
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= data_i;
    end
  end

endmodule

// ===== src/dsmpo_front.sv =====
// ----------------------------------------------------------------------------
// dsmpo_front: request intake and classification
// Accepts requests, marks those with an unused mode or addressing no page and queues them.
// ----------------------------------------------------------------------------
module dsmpo_front #(
  parameter int unsigned FILES          = dsmpo_pkg::FilesDefault,
  parameter int unsigned PAGES_PER_FILE = dsmpo_pkg::PagesPerFileDefault
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  dsmpo_pkg::item_t  item_i,
  input  logic              busy_i,
  output logic              full_o,
  input  logic              cmd_pop_i,
  output dsmpo_pkg::cmd_t   cmd_o,
  output logic              cmd_empty_o
);

  dsmpo_pkg::cmd_t cmd_in;
  logic            q_full;
  logic            q_push;

  // Classify: an unused mode or a page beyond the table is marked and leaves the table unchanged.
  always_comb begin
    cmd_in.item = item_i;
    cmd_in.oor  = (item_i.mode > dsmpo_pkg::MODE_WRITE_REPLY) ||
                  (32'(item_i.file_id) >= 32'(FILES)) ||
                  (32'(item_i.page_index) >= 32'(PAGES_PER_FILE));
  end

  assign full_o = q_full || busy_i;
  assign q_push = push_i && !full_o;

  dsmpo_fifo #(
    .Width ($bits(dsmpo_pkg::cmd_t))
  ) u_cmd_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .data_i  (cmd_in),
    .full_o  (q_full),
    .pop_i   (cmd_pop_i),
    .data_o  (cmd_o),
    .empty_o (cmd_empty_o)
  );

endmodule

// ===== src/dsmpo_back.sv =====
// ----------------------------------------------------------------------------
// dsmpo_back: page table engine
// Reads the page entry, applies the protocol, writes it back and emits the
// messages, walking the copyset on a write upgrade. Clears the table after
// reset.
// ----------------------------------------------------------------------------
module dsmpo_back #(
  parameter int unsigned NODES          = dsmpo_pkg::NodesDefault,
  parameter int unsigned FILES          = dsmpo_pkg::FilesDefault,
  parameter int unsigned PAGES_PER_FILE = dsmpo_pkg::PagesPerFileDefault
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic [3:0]         node_id_i,
  input  logic [3:0]         main_node_id_i,
  output logic               busy_o,
  input  dsmpo_pkg::cmd_t    cmd_i,
  input  logic               cmd_empty_i,
  output logic               cmd_pop_o,
  output logic               res_push_o,
  output dsmpo_pkg::result_t res_o,
  input  logic               res_full_i
);

  localparam int unsigned Depth = FILES * PAGES_PER_FILE;
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_WALK
  } state_e;

  state_e             state_q, state_d;
  dsmpo_pkg::cmd_t    cur_q;
  logic [15:0]        walk_q, walk_d;
  logic [AddrW:0]     clr_q;
  logic               clearing;

  logic [31:0]        head_lin, cur_lin;
  logic [AddrW-1:0]   head_idx, cur_idx;
  logic [dsmpo_pkg::EntryWidth-1:0] rdata;
  logic               ram_we, ram_re;
  logic [AddrW-1:0]   ram_waddr;
  dsmpo_pkg::entry_t  ram_wdata;

  dsmpo_pkg::entry_t  ne;
  dsmpo_pkg::result_t exec_res, walk_res;
  logic               exec_wr, walk_go;
  logic [15:0]        walk_init, low_bit;
  logic [3:0]         low_idx;
  logic [15:0]        nm, nbit;
  logic               is_main;

  assign clearing = (clr_q != (AddrW+1)'(Depth));
  assign busy_o   = clearing;
  assign nm       = dsmpo_pkg::node_mask(NODES);
  assign nbit     = 16'd1 << node_id_i;
  assign is_main  = (node_id_i == main_node_id_i);

  // Table index of the queue head and of the request being served.
  assign head_lin = 32'(cmd_i.item.file_id) * 32'(PAGES_PER_FILE) +
                    32'(cmd_i.item.page_index);
  assign cur_lin  = 32'(cur_q.item.file_id) * 32'(PAGES_PER_FILE) +
                    32'(cur_q.item.page_index);
  assign head_idx = head_lin[AddrW-1:0];
  assign cur_idx  = cur_lin[AddrW-1:0];

  // Protocol decision on the entry just read.
  always_comb begin
    dsmpo_pkg::entry_t e;
    logic [15:0] cs;
    e         = rdata;
    cs        = 16'd0;
    ne        = e;
    exec_wr   = 1'b0;
    walk_go   = 1'b0;
    walk_init = 16'd0;
    exec_res             = '0;
    exec_res.action      = dsmpo_pkg::ACT_NONE;
    exec_res.dest_node   = node_id_i;
    exec_res.msg_src     = node_id_i;
    exec_res.file_out    = cur_q.item.file_id;
    exec_res.page_out    = cur_q.item.page_index;
    exec_res.tag_out     = cur_q.item.request_tag;
    exec_res.last        = 1'b1;
    if (!cur_q.oor) begin
      if (!e.created && (cur_q.item.mode <= dsmpo_pkg::MODE_REMOTE_INVAL) && !is_main) begin
        // Remote traffic for a page this node never held.
        exec_res.msg_src = cur_q.item.src_node;
        if (cur_q.item.mode == dsmpo_pkg::MODE_REMOTE_INVAL) begin
          exec_res.action    = dsmpo_pkg::ACT_ACK;
          exec_res.dest_node = cur_q.item.src_node;
        end else begin
          exec_res.action    = (cur_q.item.mode == dsmpo_pkg::MODE_REMOTE_READ) ?
                               dsmpo_pkg::ACT_FWD_READ : dsmpo_pkg::ACT_FWD_WRITE;
          exec_res.dest_node = main_node_id_i;
        end
      end else begin
        if (!e.created) begin
          e.created = 1'b1;
          e.copyset = 16'd0;
          e.owner   = main_node_id_i;
          e.write   = 1'b0;
          e.valid   = is_main;
        end
        ne      = e;
        exec_wr = 1'b1;
        cs      = e.copyset;
        unique case (cur_q.item.mode)
          dsmpo_pkg::MODE_REMOTE_READ, dsmpo_pkg::MODE_REMOTE_WRITE: begin
            exec_res.msg_src = cur_q.item.src_node;
            if (e.owner == node_id_i) begin
              exec_res.action    = dsmpo_pkg::ACT_RESP;
              exec_res.dest_node = cur_q.item.src_node;
              if (cur_q.item.mode == dsmpo_pkg::MODE_REMOTE_READ) begin
                cs                  = (cs | nbit) & nm;
                exec_res.drop_write = e.write;
                ne.valid            = 1'b1;
              end else begin
                exec_res.drop_all = 1'b1;
                ne.valid          = 1'b0;
              end
              ne.write             = 1'b0;
              exec_res.copyset_out = cs;
            end else begin
              exec_res.action    = (cur_q.item.mode == dsmpo_pkg::MODE_REMOTE_READ) ?
                                   dsmpo_pkg::ACT_FWD_READ : dsmpo_pkg::ACT_FWD_WRITE;
              exec_res.dest_node = e.owner;
            end
            ne.owner = cur_q.item.src_node;
          end
          dsmpo_pkg::MODE_REMOTE_INVAL: begin
            ne.valid           = 1'b0;
            ne.write           = 1'b0;
            exec_res.action    = dsmpo_pkg::ACT_ACK;
            exec_res.dest_node = cur_q.item.src_node;
            exec_res.msg_src   = cur_q.item.src_node;
            exec_res.drop_all  = 1'b1;
          end
          dsmpo_pkg::MODE_LOCAL_READ, dsmpo_pkg::MODE_READ_REPLY: begin
            if ((cur_q.item.mode == dsmpo_pkg::MODE_LOCAL_READ) &&
                (e.owner != node_id_i)) begin
              exec_res.action    = dsmpo_pkg::ACT_READ_REQ;
              exec_res.dest_node = e.owner;
            end else begin
              if (cur_q.item.mode == dsmpo_pkg::MODE_READ_REPLY) begin
                cs = cur_q.item.copyset_in & nm;
              end
              ne.owner        = node_id_i;
              ne.valid        = 1'b1;
              ne.write        = 1'b0;
              exec_res.action = dsmpo_pkg::ACT_GRANT;
            end
          end
          dsmpo_pkg::MODE_LOCAL_WRITE, dsmpo_pkg::MODE_WRITE_REPLY: begin
            if ((cur_q.item.mode == dsmpo_pkg::MODE_LOCAL_WRITE) &&
                (e.owner != node_id_i)) begin
              exec_res.action    = dsmpo_pkg::ACT_WRITE_REQ;
              exec_res.dest_node = e.owner;
            end else begin
              if (cur_q.item.mode == dsmpo_pkg::MODE_WRITE_REPLY) begin
                cs = cur_q.item.copyset_in & nm;
              end
              // Every sharer but this node is invalidated by the walk.
              walk_init = cs & ~nbit;
              cs        = cs & nbit;
              walk_go   = 1'b1;
              ne.owner  = node_id_i;
              ne.valid  = 1'b1;
              ne.write  = 1'b1;
            end
          end
          default: begin
            exec_wr = 1'b0;
          end
        endcase
        ne.copyset = cs & nm;
      end
    end
  end

  // Lowest remaining sharer of the invalidate walk.
  always_comb begin
    low_bit = walk_q & (~walk_q + 16'd1);
    low_idx = 4'd0;
    for (int i = 0; i < 16; i++) begin
      if (low_bit[i]) begin
        low_idx = low_idx | 4'(i);
      end
    end
  end

  // Invalidate or final grant of a write upgrade.
  always_comb begin
    walk_res          = '0;
    walk_res.msg_src  = node_id_i;
    walk_res.file_out = cur_q.item.file_id;
    walk_res.page_out = cur_q.item.page_index;
    walk_res.tag_out  = cur_q.item.request_tag;
    if (walk_q != 16'd0) begin
      walk_res.action    = dsmpo_pkg::ACT_INVAL;
      walk_res.dest_node = low_idx;
    end else begin
      walk_res.action      = dsmpo_pkg::ACT_GRANT;
      walk_res.dest_node   = node_id_i;
      walk_res.grant_write = 1'b1;
      walk_res.last        = 1'b1;
    end
  end

  // Sequencing of lookup, update and message output.
  always_comb begin
    state_d    = state_q;
    walk_d     = walk_q;
    cmd_pop_o  = 1'b0;
    ram_re     = 1'b0;
    res_push_o = 1'b0;
    res_o      = exec_res;
    ram_we     = clearing;
    ram_waddr  = clr_q[AddrW-1:0];
    ram_wdata  = '0;
    unique case (state_q)
      S_IDLE: begin
        if (!clearing && !cmd_empty_i) begin
          cmd_pop_o = 1'b1;
          ram_re    = 1'b1;
          state_d   = S_EXEC;
        end
      end
      S_EXEC: begin
        if (walk_go || !res_full_i) begin
          ram_we    = exec_wr;
          ram_waddr = cur_idx;
          ram_wdata = ne;
          if (walk_go) begin
            walk_d  = walk_init;
            state_d = S_WALK;
          end else begin
            res_push_o = 1'b1;
            state_d    = S_IDLE;
          end
        end
      end
      S_WALK: begin
        res_o = walk_res;
        if (!res_full_i) begin
          res_push_o = 1'b1;
          walk_d     = walk_q & ~low_bit;
          if (walk_q == 16'd0) begin
            state_d = S_IDLE;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // State, current request, walk mask and clearing counter.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      walk_q  <= 16'd0;
      clr_q   <= '0;
      cur_q   <= '0;
    end else begin
      state_q <= state_d;
      walk_q  <= walk_d;
      if (clearing) begin
        clr_q <= clr_q + 1'b1;
      end
      if (cmd_pop_o) begin
        cur_q <= cmd_i;
      end
    end
  end

  dsmpo_ram #(
    .Width (dsmpo_pkg::EntryWidth),
    .Depth (Depth)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (head_idx),
    .rdata_o (rdata)
  );

endmodule

// ===== src/dsm_page_ownership_protocol.sv =====
// ----------------------------------------------------------------------------
// dsm_page_ownership_protocol: per-page ownership engine
// Probable-owner and copyset coherence for distributed shared memory.
//
//   Channel   Signals                               Transfer
//   request   push, full, item_i                    push & !full
//   result    empty, pop, result_o                  pop & !empty
//   config    cfg_valid_i, cfg_ready_o, index/data  valid & ready
//
// A request is served as a table read followed by the update and message.
// A write upgrade then sends one invalidate per other sharer, lowest node
// first, and the grant. After reset the table is cleared, one entry a
// cycle, all FILES * PAGES_PER_FILE entries (1024 by default), with full
// held high. A full result queue stalls the table engine; the request
// queue keeps accepting until its two entries are taken.
// ----------------------------------------------------------------------------
module dsm_page_ownership_protocol #(
  parameter int unsigned NODES          = dsmpo_pkg::NodesDefault,
  parameter int unsigned FILES          = dsmpo_pkg::FilesDefault,
  parameter int unsigned PAGES_PER_FILE = dsmpo_pkg::PagesPerFileDefault
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push,
  output logic               full,
  input  dsmpo_pkg::item_t   item_i,
  output logic               empty,
  input  logic               pop,
  output dsmpo_pkg::result_t result_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [1:0]         cfg_index_i,
  input  logic [3:0]         cfg_data_i
);

  logic [3:0]         node_id_q, main_node_id_q;
  logic               busy;
  dsmpo_pkg::cmd_t    cmd;
  logic               cmd_empty, cmd_pop;
  logic               res_push, res_full;
  dsmpo_pkg::result_t res;

  assign cfg_ready_o = 1'b1;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      node_id_q      <= 4'd0;
      main_node_id_q <= 4'd0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        dsmpo_pkg::REG_NODE_ID:      node_id_q      <= cfg_data_i;
        dsmpo_pkg::REG_MAIN_NODE_ID: main_node_id_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  dsmpo_front #(
    .FILES          (FILES),
    .PAGES_PER_FILE (PAGES_PER_FILE)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .item_i      (item_i),
    .busy_i      (busy),
    .full_o      (full),
    .cmd_pop_i   (cmd_pop),
    .cmd_o       (cmd),
    .cmd_empty_o (cmd_empty)
  );

  dsmpo_back #(
    .NODES          (NODES),
    .FILES          (FILES),
    .PAGES_PER_FILE (PAGES_PER_FILE)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .node_id_i      (node_id_q),
    .main_node_id_i (main_node_id_q),
    .busy_o         (busy),
    .cmd_i          (cmd),
    .cmd_empty_i    (cmd_empty),
    .cmd_pop_o      (cmd_pop),
    .res_push_o     (res_push),
    .res_o          (res),
    .res_full_i     (res_full)
  );

  dsmpo_fifo #(
    .Width ($bits(dsmpo_pkg::result_t))
  ) u_res_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .data_i  (res),
    .full_o  (res_full),
    .pop_i   (pop),
    .data_o  (result_o),
    .empty_o (empty)
  );

endmodule

// ===== src/dsmpo_checker.sv =====
// ----------------------------------------------------------------------------
// dsmpo_checker: port-level checks of the ownership engine
// Watches the result port for stability and for consistent message flags.
// ----------------------------------------------------------------------------
module dsmpo_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               empty,
  input logic               pop,
  input dsmpo_pkg::result_t result_o
);

  // A waiting result holds until it is taken.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> (!empty && $stable(result_o)))
    else $error("result changed while stalled");

  // Writable access is only ever granted in a grant.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && result_o.grant_write) |-> (result_o.action == dsmpo_pkg::ACT_GRANT))
    else $error("grant_write outside a grant");

  // A copyset travels only with a page response.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && (result_o.copyset_out != 16'd0)) |->
      (result_o.action == dsmpo_pkg::ACT_RESP))
    else $error("copyset outside a page response");

  // Invalidates are never the final message of a request.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && (result_o.action == dsmpo_pkg::ACT_INVAL)) |-> !result_o.last)
    else $error("invalidate marked last");

endmodule

bind dsm_page_ownership_protocol dsmpo_checker u_checker (
  .clk_i    (clk_i),
  .rst_ni   (rst_ni),
  .empty    (empty),
  .pop      (pop),
  .result_o (result_o)
);

// ===== tb/sv/tb_dsm_page_ownership_protocol.sv =====
// ----------------------------------------------------------------------------
// tb_dsm_page_ownership_protocol: self-checking bench of the ownership engine
// Sends directed and random page requests through several node settings,
// predicts every message with a behavioural page table and compares each
// popped result as a whole against the oldest prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_dsm_page_ownership_protocol;

  localparam int unsigned PageCount =
    dsmpo_pkg::FilesDefault * dsmpo_pkg::PagesPerFileDefault;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               push = 1'b0;
  logic               full;
  dsmpo_pkg::item_t   item_i = '0;
  logic               empty;
  logic               pop = 1'b0;
  dsmpo_pkg::result_t result_o;
  logic               cfg_valid_i = 1'b0;
  logic               cfg_ready_o;
  logic [1:0]         cfg_index_i = '0;
  logic [3:0]         cfg_data_i = '0;

  // Predicted page table and register copies.
  dsmpo_pkg::entry_t page_model [PageCount];
  logic [3:0]        my_node;
  logic [3:0]        home_node;

  dsmpo_pkg::result_t expected_msgs [$];
  int unsigned mismatches = 0;
  int unsigned msgs_checked = 0;
  int unsigned requests_sent = 0;
  bit          hold_pop = 1'b0;
  bit          no_idle = 1'b0;
  bit          done = 1'b0;

  dsm_page_ownership_protocol dut (.*);

  // Clock.
  always #4 clk_i = ~clk_i;

  // Adds one predicted message.
  function automatic void add_msg(logic [3:0] act, logic [3:0] dest, logic [3:0] src,
                                  dsmpo_pkg::item_t it, logic [15:0] cs, logic dw,
                                  logic da, logic gw);
    dsmpo_pkg::result_t r;
    r.action = act; r.dest_node = dest; r.msg_src = src;
    r.file_out = it.file_id; r.page_out = it.page_index;
    r.copyset_out = cs; r.tag_out = it.request_tag;
    r.drop_write = dw; r.drop_all = da; r.grant_write = gw; r.last = 1'b0;
    expected_msgs.push_back(r);
  endfunction

  // Predicts the messages of one request and updates the page table copy.
  function automatic void predict_request(dsmpo_pkg::item_t it);
    int unsigned       idx;
    dsmpo_pkg::entry_t e;
    logic [3:0]        owner;
    logic [15:0]       cs;
    logic              vld, wr;
    bit                is_main;
    is_main = (my_node == home_node);
    if (it.mode > dsmpo_pkg::MODE_WRITE_REPLY) begin
      add_msg(dsmpo_pkg::ACT_NONE, my_node, my_node, it, '0, 1'b0, 1'b0, 1'b0);
      expected_msgs[$].last = 1'b1;
      return;
    end
    idx = it.file_id * dsmpo_pkg::PagesPerFileDefault + it.page_index;
    e = page_model[idx];
    if (!e.created) begin
      if (it.mode <= dsmpo_pkg::MODE_REMOTE_INVAL && !is_main) begin
        if (it.mode == dsmpo_pkg::MODE_REMOTE_INVAL)
          add_msg(dsmpo_pkg::ACT_ACK, it.src_node, it.src_node, it, '0,
                  1'b0, 1'b0, 1'b0);
        else
          add_msg(it.mode == dsmpo_pkg::MODE_REMOTE_READ ?
                  dsmpo_pkg::ACT_FWD_READ : dsmpo_pkg::ACT_FWD_WRITE,
                  home_node, it.src_node, it, '0, 1'b0, 1'b0, 1'b0);
        expected_msgs[$].last = 1'b1;
        return;
      end
      e = '0;
      e.created = 1'b1;
      e.valid = is_main;
      e.owner = home_node;
    end
    owner = e.owner; cs = e.copyset; vld = e.valid; wr = e.write;
    case (it.mode)
      dsmpo_pkg::MODE_REMOTE_READ, dsmpo_pkg::MODE_REMOTE_WRITE: begin
        if (owner == my_node) begin
          if (it.mode == dsmpo_pkg::MODE_REMOTE_READ) begin
            cs[my_node] = 1'b1;
            add_msg(dsmpo_pkg::ACT_RESP, it.src_node, it.src_node, it, cs, wr,
                    1'b0, 1'b0);
            vld = 1'b1; wr = 1'b0;
          end else begin
            add_msg(dsmpo_pkg::ACT_RESP, it.src_node, it.src_node, it, cs, 1'b0,
                    1'b1, 1'b0);
            vld = 1'b0; wr = 1'b0;
          end
        end else begin
          add_msg(it.mode == dsmpo_pkg::MODE_REMOTE_READ ?
                  dsmpo_pkg::ACT_FWD_READ : dsmpo_pkg::ACT_FWD_WRITE,
                  owner, it.src_node, it, '0, 1'b0, 1'b0, 1'b0);
        end
        owner = it.src_node;
      end
      dsmpo_pkg::MODE_REMOTE_INVAL: begin
        vld = 1'b0; wr = 1'b0;
        add_msg(dsmpo_pkg::ACT_ACK, it.src_node, it.src_node, it, '0, 1'b0, 1'b1, 1'b0);
      end
      dsmpo_pkg::MODE_LOCAL_READ, dsmpo_pkg::MODE_READ_REPLY: begin
        if (it.mode == dsmpo_pkg::MODE_LOCAL_READ && owner != my_node) begin
          add_msg(dsmpo_pkg::ACT_READ_REQ, owner, my_node, it, '0, 1'b0, 1'b0, 1'b0);
        end else begin
          if (it.mode == dsmpo_pkg::MODE_READ_REPLY) cs = it.copyset_in;
          owner = my_node; vld = 1'b1; wr = 1'b0;
          add_msg(dsmpo_pkg::ACT_GRANT, my_node, my_node, it, '0, 1'b0, 1'b0, 1'b0);
        end
      end
      default: begin
        if (it.mode == dsmpo_pkg::MODE_LOCAL_WRITE && owner != my_node) begin
          add_msg(dsmpo_pkg::ACT_WRITE_REQ, owner, my_node, it, '0, 1'b0, 1'b0, 1'b0);
        end else begin
          if (it.mode == dsmpo_pkg::MODE_WRITE_REPLY) cs = it.copyset_in;
          // Every other sharer is invalidated in ascending node order.
          for (int n = 0; n < 16; n++) begin
            if (n != my_node && cs[n]) begin
              add_msg(dsmpo_pkg::ACT_INVAL, 4'(n), my_node, it, '0, 1'b0, 1'b0, 1'b0);
              cs[n] = 1'b0;
            end
          end
          owner = my_node; vld = 1'b1; wr = 1'b1;
          add_msg(dsmpo_pkg::ACT_GRANT, my_node, my_node, it, '0, 1'b0, 1'b0, 1'b1);
        end
      end
    endcase
    e.created = 1'b1; e.copyset = cs; e.owner = owner; e.valid = vld; e.write = wr;
    page_model[idx] = e;
    expected_msgs[$].last = 1'b1;
  endfunction

  // Random idle decision for either side.
  function automatic bit idle_now();
    return !no_idle && ($urandom_range(99) < 21);
  endfunction

  // Sends one request and predicts its messages once it is taken. The push
  // stays high afterwards so that the next request can follow at once.
  task automatic send_request(dsmpo_pkg::item_t it);
    while (idle_now()) begin
      push <= 1'b0;
      @(posedge clk_i);
    end
    push <= 1'b1;
    item_i <= it;
    do @(posedge clk_i); while (full);
    predict_request(it);
    requests_sent++;
  endtask

  // Ends a run of requests.
  task automatic stop_requests();
    push <= 1'b0;
  endtask

  task automatic wait_drained();
    while (expected_msgs.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
  endtask

  // Writes one register; callers are to do so while the engine is idle, which the task does not enforce.
  task automatic write_reg(logic [1:0] index, logic [3:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= index;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    if (index == dsmpo_pkg::REG_NODE_ID) my_node = data;
    else home_node = data;
    @(posedge clk_i);
  endtask

  function automatic dsmpo_pkg::item_t make_item(logic [2:0] mode, logic [1:0] file,
                                                 logic [7:0] page, logic [3:0] src,
                                                 logic [15:0] cs);
    dsmpo_pkg::item_t it;
    it.mode = mode; it.file_id = file; it.page_index = page;
    it.src_node = src; it.copyset_in = cs; it.request_tag = 16'($urandom);
    return it;
  endfunction

  // Result side: pops with random idling and compares with the oldest prediction.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (pop && !empty) begin
        if (expected_msgs.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected message %h", result_o);
        end else begin
          if (result_o !== expected_msgs[0]) begin
            mismatches++;
            if (mismatches <= 10)
              $display("message mismatch: expected %h got %h", expected_msgs[0], result_o);
          end
          void'(expected_msgs.pop_front());
          msgs_checked++;
        end
      end
      pop <= !hold_pop && !idle_now();
    end
  end

  // Directed: page creation, ownership moves, faults, replies and oddities.
  task automatic test_directed();
    dsmpo_pkg::item_t it;
    write_reg(dsmpo_pkg::REG_NODE_ID, 4'd0);
    write_reg(dsmpo_pkg::REG_MAIN_NODE_ID, 4'd0);
    send_request(make_item(dsmpo_pkg::MODE_LOCAL_READ, 2'd0, 8'd0, 4'd0, '0));
    send_request(make_item(dsmpo_pkg::MODE_LOCAL_WRITE, 2'd0, 8'd0, 4'd0, '0));
    send_request(make_item(dsmpo_pkg::MODE_REMOTE_READ, 2'd0, 8'd0, 4'd15, '0));
    send_request(make_item(dsmpo_pkg::MODE_REMOTE_READ, 2'd0, 8'd0, 4'd3, '0));
    send_request(make_item(dsmpo_pkg::MODE_LOCAL_WRITE, 2'd0, 8'd0, 4'd0, '0));
    send_request(make_item(dsmpo_pkg::MODE_WRITE_REPLY, 2'd3, 8'd255, 4'd0, 16'hFFFF));
    send_request(make_item(dsmpo_pkg::MODE_REMOTE_WRITE, 2'd3, 8'd255, 4'd9, '0));
    send_request(make_item(dsmpo_pkg::MODE_REMOTE_WRITE, 2'd3, 8'd255, 4'd4, '0));
    send_request(make_item(dsmpo_pkg::MODE_REMOTE_INVAL, 2'd1, 8'd7, 4'd2, '0));
    send_request(make_item(dsmpo_pkg::MODE_READ_REPLY, 2'd1, 8'd7, 4'd0, 16'hA5A5));
    it = make_item(3'd7, 2'd2, 8'd1, 4'd1, 16'h1234);
    it.request_tag = 16'hFFFF;
    send_request(it);
    stop_requests();
    wait_drained();
    write_reg(dsmpo_pkg::REG_NODE_ID, 4'd15);
    write_reg(dsmpo_pkg::REG_MAIN_NODE_ID, 4'd0);
    send_request(make_item(dsmpo_pkg::MODE_REMOTE_READ, 2'd2, 8'd2, 4'd5, '0));
    send_request(make_item(dsmpo_pkg::MODE_REMOTE_WRITE, 2'd2, 8'd3, 4'd6, '0));
    send_request(make_item(dsmpo_pkg::MODE_REMOTE_INVAL, 2'd2, 8'd4, 4'd7, '0));
    send_request(make_item(dsmpo_pkg::MODE_LOCAL_READ, 2'd2, 8'd5, 4'd0, '0));
    send_request(make_item(dsmpo_pkg::MODE_READ_REPLY, 2'd2, 8'd5, 4'd0, 16'h8001));
    send_request(make_item(dsmpo_pkg::MODE_LOCAL_WRITE, 2'd2, 8'd5, 4'd0, '0));
    send_request(make_item(dsmpo_pkg::MODE_REMOTE_READ, 2'd2, 8'd5, 4'd1, '0));
    stop_requests();
    wait_drained();
  endtask

  // Random traffic on a small page set so that pages are revisited.
  task automatic test_random(int unsigned count);
    dsmpo_pkg::item_t it;
    for (int i = 0; i < count; i++) begin
      if (i % 40 == 0) begin
        stop_requests();
        wait_drained();
        write_reg(dsmpo_pkg::REG_NODE_ID, 4'($urandom));
        write_reg(dsmpo_pkg::REG_MAIN_NODE_ID,
                  ($urandom_range(1) != 0) ? my_node : 4'($urandom));
      end
      it = dsmpo_pkg::item_t'($bits(dsmpo_pkg::item_t)'({$urandom, $urandom}));
      if ($urandom_range(9) < 8) begin
        it.mode = 3'($urandom_range(6));
        it.file_id = 2'($urandom_range(1));
        it.page_index = 8'($urandom_range(7));
      end
      no_idle = (i >= 60 && i < 80);
      send_request(it);
    end
    stop_requests();
    no_idle = 1'b0;
  endtask

  // Receiver holds off while requests keep coming, then the sender waits it out.
  task automatic test_backpressure();
    fork
      begin
        hold_pop = 1'b1;
        repeat (150) @(posedge clk_i);
        hold_pop = 1'b0;
      end
      begin
        for (int i = 0; i < 12; i++)
          send_request(make_item(dsmpo_pkg::MODE_WRITE_REPLY, 2'd1, 8'(i), 4'd0,
                                 16'($urandom)));
        stop_requests();
      end
    join
    wait_drained();
  endtask

  initial begin
    my_node = '0;
    home_node = '0;
    foreach (page_model[i]) page_model[i] = '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_directed();
    test_random(90);
    test_backpressure();
    wait_drained();
    done = 1'b1;
    $display("Checked %0d messages from %0d requests over several node settings,",
             msgs_checked, requests_sent);
    $display("including forwarding, upgrades, replies, odd modes and a full stall.");
    if (mismatches == 0 && expected_msgs.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // Watchdog.
  initial begin
    #4ms;
    if (!done) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

endmodule

// ===== sim.f =====
src/dsmpo_pkg.sv
src/dsmpo_ram.sv
src/dsmpo_fifo.sv
src/dsmpo_front.sv
src/dsmpo_back.sv
src/dsm_page_ownership_protocol.sv
src/dsmpo_checker.sv
tb/sv/tb_dsm_page_ownership_protocol.sv
